// ===== sv/irpd_pkg.sv =====
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types and constants of the IR pulse-distance frame decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

  // Field widths
  localparam int unsigned TICKS_W  = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 3;

  // Default frame length in data bits
  localparam int unsigned FRAME_BITS_DEF = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX   = 3'd5;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] HEADER_MIN_RST = 8'h83;
  localparam logic [BYTE_W-1:0] HEADER_MAX_RST = 8'h84;
  localparam logic [BYTE_W-1:0] ONE_MIN_RST    = 8'h15;
  localparam logic [BYTE_W-1:0] ONE_MAX_RST    = 8'h16;
  localparam logic [BYTE_W-1:0] ZERO_MIN_RST   = 8'h0A;
  localparam logic [BYTE_W-1:0] ZERO_MAX_RST   = 8'h0B;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_HEADER = 2'd1,
    PH_BITS   = 2'd2
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_BADHDR = 2'd1,
    ST_BADBIT = 2'd2
  } status_e;

  typedef struct packed {
    logic [BYTE_W-1:0] header_min;
    logic [BYTE_W-1:0] header_max;
    logic [BYTE_W-1:0] one_min;
    logic [BYTE_W-1:0] one_max;
    logic [BYTE_W-1:0] zero_min;
    logic [BYTE_W-1:0] zero_max;
  } cfg_t;

  typedef struct packed {
    logic hdr_ok;
    logic is_one;
    logic is_zero;
  } cls_t;

endpackage

// ===== sv/irpd_stream_if.sv =====
// ----------------------------------------------------------------------------
// irpd_stream_if
// Valid/ready channels of the decoder: interval words in, frame words out.
// ----------------------------------------------------------------------------
interface irpd_in_if;
  logic                          valid;
  logic                          ready;
  logic [irpd_pkg::TICKS_W-1:0]  interval_ticks;

  modport source (output valid, output interval_ticks, input ready);
  modport sink   (input valid, input interval_ticks, output ready);
endinterface

interface irpd_out_if;
  logic                          valid;
  logic                          ready;
  logic [irpd_pkg::CODE_W-1:0]   code;
  logic [irpd_pkg::CNT_W-1:0]    bits_received;
  logic [irpd_pkg::STATUS_W-1:0] status;

  modport source (output valid, output code, output bits_received, output status,
                  input ready);
  modport sink   (input valid, input code, input bits_received, input status,
                  output ready);
endinterface

// ===== sv/irpd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// irpd_cfg_regs
// Window threshold registers, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module irpd_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [irpd_pkg::BYTE_W-1:0]     cfg_wdata_i,
  output irpd_pkg::cfg_t                  cfg_o
);
  import irpd_pkg::*;

  cfg_t cfg_q;

  // Update the addressed register; drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{header_min: HEADER_MIN_RST, header_max: HEADER_MAX_RST,
                 one_min:    ONE_MIN_RST,    one_max:    ONE_MAX_RST,
                 zero_min:   ZERO_MIN_RST,   zero_max:   ZERO_MAX_RST};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEADER_MIN: cfg_q.header_min <= cfg_wdata_i;
        CFG_HEADER_MAX: cfg_q.header_max <= cfg_wdata_i;
        CFG_ONE_MIN:    cfg_q.one_min    <= cfg_wdata_i;
        CFG_ONE_MAX:    cfg_q.one_max    <= cfg_wdata_i;
        CFG_ZERO_MIN:   cfg_q.zero_min   <= cfg_wdata_i;
        CFG_ZERO_MAX:   cfg_q.zero_max   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/irpd_classify.sv =====
// ----------------------------------------------------------------------------
// irpd_classify
// Window compares on the interval upper byte: header, logic one, logic zero.
// ----------------------------------------------------------------------------
module irpd_classify (
  input  logic [irpd_pkg::BYTE_W-1:0] hb_i,
  input  irpd_pkg::cfg_t              cfg_i,
  output irpd_pkg::cls_t              cls_o
);
  import irpd_pkg::*;

  logic in_one;
  logic in_zero;

  // An empty window (min above max) accepts nothing by construction
  assign in_one  = (hb_i >= cfg_i.one_min)  && (hb_i <= cfg_i.one_max);
  assign in_zero = (hb_i >= cfg_i.zero_min) && (hb_i <= cfg_i.zero_max);

  // The one window takes priority where the windows overlap
  assign cls_o.hdr_ok  = (hb_i >= cfg_i.header_min) && (hb_i <= cfg_i.header_max);
  assign cls_o.is_one  = in_one;
  assign cls_o.is_zero = !in_one && in_zero;

endmodule

// ===== sv/irpd_frame.sv =====
// ----------------------------------------------------------------------------
// irpd_frame
// Input register, frame state machine and result register of the decoder.
// ----------------------------------------------------------------------------
module irpd_frame #(
  parameter int unsigned FRAME_BITS = irpd_pkg::FRAME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  irpd_in_if.sink                       in_i,
  irpd_out_if.source                    out_o,
  output logic [irpd_pkg::BYTE_W-1:0]   hb_o,
  input  irpd_pkg::cls_t                cls_i
);
  import irpd_pkg::*;

  localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BITS);

  logic                in_vld_q;
  logic [TICKS_W-1:0]  ticks_q;

  phase_e              phase_q, phase_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CODE_W-1:0]   shift_q, shift_d;

  logic                out_vld_q;
  logic [CODE_W-1:0]   code_q;
  logic [CNT_W-1:0]    bits_q;
  status_e             status_q;

  logic                emit;
  logic [CODE_W-1:0]   res_code;
  logic [CNT_W-1:0]    res_bits;
  status_e             res_status;
  logic                slot_free;
  logic                adv;

  assign hb_o = ticks_q[TICKS_W-1:TICKS_W-BYTE_W];

  // Next state and result of the held word
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    shift_d    = shift_q;
    emit       = 1'b0;
    res_code   = '0;
    res_bits   = '0;
    res_status = ST_DONE;
    case (phase_q)
      PH_HEADER: begin
        if (cls_i.hdr_ok) begin
          phase_d = PH_BITS;
          cnt_d   = '0;
          shift_d = '0;
        end else begin
          phase_d    = PH_FIRST;
          emit       = 1'b1;
          res_status = ST_BADHDR;
        end
      end
      PH_BITS: begin
        if (!cls_i.is_one && !cls_i.is_zero) begin
          phase_d    = PH_FIRST;
          emit       = 1'b1;
          res_code   = shift_q;
          res_bits   = cnt_q;
          res_status = ST_BADBIT;
        end else begin
          shift_d = {shift_q[CODE_W-2:0], cls_i.is_one};
          cnt_d   = cnt_q + CNT_W'(1);
          if (cnt_d >= FRAME_CNT) begin
            phase_d    = PH_FIRST;
            emit       = 1'b1;
            res_code   = shift_d;
            res_bits   = cnt_d;
            res_status = ST_DONE;
          end
        end
      end
      default: begin
        // First edge of a frame, also the unused phase code
        phase_d = PH_HEADER;
      end
    endcase
  end

  // Advance the held word unless it carries a result and the slot is taken
  assign slot_free = !out_vld_q || out_o.ready;
  assign adv       = in_vld_q && (!emit || slot_free);
  assign in_i.ready = !in_vld_q || adv;

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  // Input payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ticks_q <= in_i.interval_ticks;
    end
  end

  // Frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      cnt_q   <= '0;
      shift_q <= '0;
    end else if (adv) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
    end
  end

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && emit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      code_q   <= res_code;
      bits_q   <= res_bits;
      status_q <= res_status;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.code          = code_q;
  assign out_o.bits_received = bits_q;
  assign out_o.status        = status_q;

`ifndef SYNTHESIS
  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BITS |-> cnt_q < FRAME_CNT)
    else $error("bit count reached frame length while still receiving");

  a_badhdr_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && status_q == ST_BADHDR |-> code_q == '0 && bits_q == '0)
    else $error("bad header word carries a code or bit count");

  a_done_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && status_q == ST_DONE |-> bits_q == FRAME_CNT)
    else $error("complete frame with wrong bit count");

  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && emit |=> out_vld_q)
    else $error("result lost on its way to the output register");

  a_header_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && phase_q == PH_HEADER && cls_i.hdr_ok |=>
      phase_q == PH_BITS && cnt_q == '0 && shift_q == '0)
    else $error("good header did not start a clean frame");
`endif

endmodule

// ===== sv/ir_pulse_distance_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder
// Pulse-distance IR remote frame decoder working on measured edge intervals.
// ----------------------------------------------------------------------------
// One word per received IR edge carries the timer ticks since the previous
// edge; only the upper byte is compared with the programmable header, one and
// zero windows. The block takes one word every clock cycle unless the input
// register holds back a word; a frame-end word passes through the input
// register, where the window compares and the shift are done, and then the
// result register. A word that ends a frame waits in the input
// register only while an earlier result is still untaken; words that end no
// frame pass on regardless. The first edge only starts timing, a bad header
// returns code 0 with status bad header, FRAME_BITS valid bits return the
// last 16 bits with status complete, and an invalid interval returns the
// partial code with status invalid bit. Write the thresholds only while idle.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder #(
  parameter int unsigned FRAME_BITS = irpd_pkg::FRAME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  irpd_in_if.sink                         in_i,
  irpd_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [irpd_pkg::BYTE_W-1:0]     cfg_wdata_i
);
  import irpd_pkg::*;

  cfg_t              cfg;
  cls_t              cls;
  logic [BYTE_W-1:0] hb;

  // Threshold registers
  irpd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Window compares on the held interval
  irpd_classify u_classify (
    .hb_i  (hb),
    .cfg_i (cfg),
    .cls_o (cls)
  );

  // Frame sequencing and word registers
  irpd_frame #(
    .FRAME_BITS (FRAME_BITS)
  ) u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .hb_o   (hb),
    .cls_i  (cls)
  );

endmodule

// ===== tb/tb_ir_pulse_distance_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_ir_pulse_distance_frame_decoder
// Self-checking bench for the IR pulse-distance frame decoder.
// ----------------------------------------------------------------------------
// Interval words are driven through the valid/ready input channel and every
// accepted word is run through a cycle-free decoder model that queues the
// frame words it should cause. Frame words leaving the block are compared
// field by field with the oldest queued one. Window registers are changed
// only while the block is idle, across a range of settings that covers
// full, single-value, empty and overlapping windows. Both channels pause at
// random, and one stretch keeps the output stalled until the input backs up.
// ----------------------------------------------------------------------------
module tb_ir_pulse_distance_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import irpd_pkg::*;

  localparam int unsigned FRAME_LEN     = FRAME_BITS_DEF;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 400;

  // Indexes past the register list; writes to them must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum int {
    FR_COMPLETE,
    FR_BROKEN,
    FR_BAD_HEADER
  } frame_kind_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CNT_W-1:0]  bits_received;
    status_e           status;
  } frame_word_t;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [BYTE_W-1:0]    cfg_wdata = '0;

  irpd_in_if  in_if ();
  irpd_out_if out_if ();

  ir_pulse_distance_frame_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Decoder model state
  cfg_t              win;
  phase_e            ph;
  logic [CNT_W-1:0]  bit_cnt;
  logic [CODE_W-1:0] code_sr;
  frame_word_t       expected_frames[$];

  // Run bookkeeping
  bit idle_on       = 1'b1;
  int sink_hold     = 0;
  int words_sent    = 0;
  int frames_seen   = 0;
  int mismatches    = 0;
  int settings_used = 0;

  // Free-running clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("ir_pulse_distance_frame_decoder verification failed");
    $finish;
  end

  function automatic bit in_win(input logic [7:0] b, input logic [7:0] lo,
                                input logic [7:0] hi);
    return (b >= lo) && (b <= hi);
  endfunction

  // Advance the model by one interval word and queue any frame word
  function automatic void decode_interval(input logic [TICKS_W-1:0] ticks);
    logic [7:0] hb;
    logic       one_bit;
    logic       zero_bit;
    hb = ticks[15:8];
    case (ph)
      PH_HEADER: begin
        if (in_win(hb, win.header_min, win.header_max)) begin
          ph      = PH_BITS;
          bit_cnt = '0;
          code_sr = '0;
        end else begin
          ph = PH_FIRST;
          expected_frames.push_back('{code: '0, bits_received: '0, status: ST_BADHDR});
        end
      end
      PH_BITS: begin
        one_bit  = in_win(hb, win.one_min, win.one_max);
        zero_bit = !one_bit && in_win(hb, win.zero_min, win.zero_max);
        if (!one_bit && !zero_bit) begin
          ph = PH_FIRST;
          expected_frames.push_back('{code: code_sr, bits_received: bit_cnt,
                                      status: ST_BADBIT});
        end else begin
          code_sr = {code_sr[CODE_W-2:0], one_bit};
          bit_cnt = bit_cnt + 1'b1;
          if (bit_cnt >= CNT_W'(FRAME_LEN)) begin
            ph = PH_FIRST;
            expected_frames.push_back('{code: code_sr, bits_received: bit_cnt,
                                        status: ST_DONE});
          end
        end
      end
      default: ph = PH_HEADER;
    endcase
  endfunction

  // Byte inside a window, leaning on the edges
  function automatic logic [7:0] byte_in(input logic [7:0] lo, input logic [7:0] hi);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return 8'($urandom_range(hi, lo));
    endcase
  endfunction

  // Byte outside two windows, just past an edge where possible
  function automatic bit pick_outside(input logic [7:0] lo_a, input logic [7:0] hi_a,
                                      input logic [7:0] lo_b, input logic [7:0] hi_b,
                                      output logic [7:0] b);
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0:       b = lo_a - 1'b1;
        1:       b = hi_a + 1'b1;
        2:       b = lo_b - 1'b1;
        default: b = hi_b + 1'b1;
      endcase
      if (!in_win(b, lo_a, hi_a) && !in_win(b, lo_b, hi_b)) return 1'b1;
    end
    for (int n = 0; n < 32; n++) begin
      b = 8'($urandom);
      if (!in_win(b, lo_a, hi_a) && !in_win(b, lo_b, hi_b)) return 1'b1;
    end
    for (int n = 0; n < 256; n++) begin
      b = 8'(n);
      if (!in_win(b, lo_a, hi_a) && !in_win(b, lo_b, hi_b)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Byte that decodes as a data bit, one or zero at random
  function automatic bit pick_bit(output logic [7:0] b);
    bit one_ok;
    bit zero_ok;
    one_ok  = win.one_min <= win.one_max;
    zero_ok = win.zero_min <= win.zero_max;
    b = '0;
    if (one_ok && (!zero_ok || $urandom_range(0, 1) == 0)) begin
      b = byte_in(win.one_min, win.one_max);
    end else if (zero_ok) begin
      b = byte_in(win.zero_min, win.zero_max);
    end
    return one_ok || zero_ok;
  endfunction

  // Offer one interval word and hold it until taken; called at a falling edge
  task automatic send_interval(input logic [TICKS_W-1:0] ticks);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.interval_ticks <= ticks;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    decode_interval(ticks);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_interval({b, 8'($urandom)});
  endtask

  // Drop valid and wait until every frame word is out and the pipe is empty
  task automatic drain_idle();
    in_if.valid <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Hold one register write for a cycle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
  endtask

  // Program all windows, poke the spare indexes, then release the write port
  task automatic set_windows(input cfg_t w);
    drain_idle();
    write_reg(CFG_HEADER_MIN, w.header_min);
    write_reg(CFG_HEADER_MAX, w.header_max);
    write_reg(CFG_ONE_MIN, w.one_min);
    write_reg(CFG_ONE_MAX, w.one_max);
    write_reg(CFG_ZERO_MIN, w.zero_min);
    write_reg(CFG_ZERO_MAX, w.zero_max);
    write_reg(CFG_SPARE_LO, 8'($urandom));
    write_reg(CFG_SPARE_HI, 8'($urandom));
    cfg_we <= 1'b0;
    win = w;
    settings_used++;
    @(negedge clk_i);
  endtask

  // One well-formed frame of the given kind, realigning the decoder first
  task automatic send_frame(input frame_kind_e kind);
    logic [7:0] b;
    int         stop_at;
    while (ph != PH_FIRST) send_interval(16'($urandom));
    send_interval(16'($urandom));
    if (kind == FR_BAD_HEADER &&
        pick_outside(win.header_min, win.header_max, win.header_min, win.header_max, b)) begin
      send_byte(b);
      return;
    end
    if (win.header_min <= win.header_max) send_byte(byte_in(win.header_min, win.header_max));
    else send_interval(16'($urandom));
    stop_at = (kind == FR_BROKEN) ? $urandom_range(0, FRAME_LEN - 1) : FRAME_LEN;
    for (int i = 0; i < FRAME_LEN && ph == PH_BITS; i++) begin
      if (i == stop_at && pick_outside(win.one_min, win.one_max,
                                       win.zero_min, win.zero_max, b)) begin
        send_byte(b);
      end else if (pick_bit(b)) begin
        send_byte(b);
      end else begin
        send_interval(16'($urandom));
      end
    end
  endtask

  // Mostly frames with random content, some loose words
  task automatic run_phase(input cfg_t w, input int budget, input bit press);
    int start;
    int r;
    set_windows(w);
    if (press) sink_hold = HOLD_CYCLES;
    start = words_sent;
    while (words_sent - start < budget) begin
      r = $urandom_range(0, 9);
      if (r < 4)      send_frame(FR_COMPLETE);
      else if (r < 7) send_frame(FR_BROKEN);
      else if (r < 8) send_frame(FR_BAD_HEADER);
      else            send_interval(16'($urandom));
    end
  endtask

  function automatic cfg_t reset_windows();
    return '{header_min: HEADER_MIN_RST, header_max: HEADER_MAX_RST,
             one_min: ONE_MIN_RST, one_max: ONE_MAX_RST,
             zero_min: ZERO_MIN_RST, zero_max: ZERO_MAX_RST};
  endfunction

  function automatic cfg_t random_windows();
    cfg_t w;
    w.header_min = 8'($urandom);
    w.header_max = w.header_min + 8'($urandom_range(0, 12));
    w.one_min    = 8'($urandom);
    w.one_max    = w.one_min + 8'($urandom_range(0, 30));
    w.zero_min   = 8'($urandom);
    w.zero_max   = w.zero_min + 8'($urandom_range(0, 30));
    return w;
  endfunction

  // Reset windows: header edges, bit edges, bad header, invalid bits
  task automatic test_reset_defaults();
    send_interval(16'h0000);
    send_interval(16'hFFFF);
    send_interval(16'hFFFF);
    send_interval(16'h82FF);
    send_interval(16'h1234);
    send_interval(16'h8500);
    send_interval(16'h0001);
    send_interval(16'h8300);
    send_interval(16'h1500);
    send_interval(16'h16FF);
    send_interval(16'h0A00);
    send_interval(16'h0BFF);
    send_interval(16'h0C00);
    send_interval(16'hA5A5);
    send_interval(16'h84FF);
    send_interval(16'h0900);
    send_interval(16'h5A5A);
    send_interval(16'h8380);
    send_interval(16'h1580);
    send_interval(16'h14FF);
  endtask

  // Full windows and single-value windows at both ends of the byte
  task automatic test_window_extremes();
    run_phase('{header_min: 8'h00, header_max: 8'hFF, one_min: 8'h00, one_max: 8'hFF,
                zero_min: 8'h00, zero_max: 8'hFF}, 100, 1'b0);
    run_phase('{header_min: 8'h00, header_max: 8'h00, one_min: 8'h00, one_max: 8'h00,
                zero_min: 8'hFF, zero_max: 8'hFF}, 100, 1'b0);
    run_phase('{header_min: 8'hFF, header_max: 8'hFF, one_min: 8'hFF, one_max: 8'hFF,
                zero_min: 8'h00, zero_max: 8'h00}, 100, 1'b0);
  endtask

  // One window overlapping the zero window, then empty windows
  task automatic test_overlap_and_empty();
    run_phase('{header_min: 8'h60, header_max: 8'h70, one_min: 8'h20, one_max: 8'h30,
                zero_min: 8'h28, zero_max: 8'h40}, 100, 1'b0);
    run_phase('{header_min: 8'h83, header_max: 8'h84, one_min: 8'h40, one_max: 8'h20,
                zero_min: 8'h10, zero_max: 8'h18}, 100, 1'b0);
    run_phase('{header_min: 8'h90, header_max: 8'h80, one_min: 8'h15, one_max: 8'h16,
                zero_min: 8'h30, zero_max: 8'h10}, 100, 1'b0);
  endtask

  task automatic test_random_settings();
    repeat (3) run_phase(random_windows(), 100, 1'b0);
  endtask

  // Stall the output long enough for the input to back up
  task automatic test_backpressure();
    run_phase(reset_windows(), 100, 1'b1);
  endtask

  // Back-to-back words on both sides
  task automatic test_no_idle();
    drain_idle();
    idle_on = 1'b0;
    run_phase(reset_windows(), 150, 1'b0);
  endtask

  // Pace the output ready: long hold-offs first, then random bursts
  initial begin : sink_pacer
    int burst;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        out_if.ready <= 1'b0;
        sink_hold--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 13);
        out_if.ready <= 1'b0;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each taken frame word with the oldest expectation
  always @(posedge clk_i) begin
    frame_word_t exp_w;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      frames_seen++;
      if (expected_frames.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected frame word: code %h bits %0d status %0d",
                   out_if.code, out_if.bits_received, out_if.status);
        mismatches++;
      end else begin
        exp_w = expected_frames.pop_front();
        if (out_if.code !== exp_w.code || out_if.bits_received !== exp_w.bits_received ||
            out_if.status !== exp_w.status) begin
          if (mismatches < 10)
            $display("frame word mismatch: exp %h/%0d/%0d, got %h/%0d/%0d",
                     exp_w.code, exp_w.bits_received, exp_w.status,
                     out_if.code, out_if.bits_received, out_if.status);
          mismatches++;
        end
      end
    end
  end

  // Test sequence
  initial begin
    in_if.valid          = 1'b0;
    in_if.interval_ticks = '0;
    win     = reset_windows();
    ph      = PH_FIRST;
    bit_cnt = '0;
    code_sr = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_window_extremes();
    test_overlap_and_empty();
    test_random_settings();
    test_backpressure();
    test_no_idle();

    drain_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("sent %0d interval words under %0d window settings plus reset values",
             words_sent, settings_used);
    $display("checked %0d frame words, %0d mismatched, %0d still awaited",
             frames_seen, mismatches, expected_frames.size());
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("ir_pulse_distance_frame_decoder verification clean");
    end else begin
      $display("ir_pulse_distance_frame_decoder verification failed");
    end
    $finish;
  end

endmodule
